// ===== hdl/sipf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sipf_pkg
// Shared types, constants and helpers of the SOME/IP header filter parser.
// ---------------------------------------------------------------------------
package sipf_pkg;

   localparam int POSITION_BITS     = 16;
   localparam int HDR_LEN           = 16;
   localparam int PREFIX_END        = 24;
   localparam int ENTRY_LEN         = 16;
   localparam int HDR_IDX_BITS      = $clog2(PREFIX_END);
   localparam int ENTRY_IDX_BITS    = $clog2(ENTRY_LEN);
   localparam int ENTRIES_LEFT_BITS = 28;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 8;

   localparam logic [7:0]  HEADER_OFFSET_RESET = 8'h2e;
   localparam logic [7:0]  VERSION_RESET       = 8'h01;
   localparam logic [15:0] DISCOVERY_ID        = 16'hffff;

   // discovery entry types
   localparam logic [7:0] ET_FIND_SERVICE  = 8'h00;
   localparam logic [7:0] ET_OFFER_SERVICE = 8'h01;
   localparam logic [7:0] ET_SUBSCRIBE     = 8'h06;
   localparam logic [7:0] ET_SUBSCRIBE_ACK = 8'h07;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HEADER_OFFSET    = 1'b0,
      CSR_REQUIRED_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      KIND_HEADER      = 4'd0,
      KIND_DISCOVERY   = 4'd1,
      KIND_SVC_ENTRY   = 4'd2,
      KIND_EG_ENTRY    = 4'd3,
      KIND_OTHER_ENTRY = 4'd4,
      KIND_END         = 4'd5,
      KIND_SHORT       = 4'd6,
      KIND_UNKNOWN     = 4'd7,
      KIND_BAD_VERSION = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      ST_HEADER  = 4'b0001,
      ST_PREFIX  = 4'b0010,
      ST_ENTRIES = 4'b0100,
      ST_DONE    = 4'b1000
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] svc_ident;
      logic [15:0] second_id;
      logic [15:0] third_id;
      logic [15:0] sess_ident;
      logic [31:0] long_value;
      logic [31:0] entries_bytes;
      logic [7:0]  discovery_flags;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic        end_of_packet;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } result_type;

   function automatic logic is_known(input logic [15:0] id);
      return id inside {16'hc101, 16'hc102, 16'hc103, 16'hc104, 16'hc105, 16'hc106,
                        16'hc107, 16'hc108, 16'hc109, 16'hc10a, 16'h8104, 16'h8105,
                        16'h8108, 16'h8109, 16'h8101, 16'h8102, DISCOVERY_ID};
   endfunction

endpackage

// ===== hdl/someip_header_filter_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// someip_header_filter_parser
// Byte-stream SOME/IP header filter with service-discovery entry decode.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per transaction, req_last_byte on the final byte.
//   rsp_*  : zero or one record per byte: header, discovery header, one per
//            complete 16-byte discovery entry, and exactly one record flagged
//            rsp_end_of_packet for the last byte of every frame.
//   csr_*  : header_offset (index 0) and required_version (index 1); write
//            only while the block is idle.
// Path: a byte is taken into the input register, and its record is
//   registered in the result register, which drives rsp_valid.
// Throughput: one byte per cycle while no record waits on rsp_ready. The
//   byte sits in the input register while the decode logic runs.
// Stall: while a record waits on rsp_ready, one more byte is taken into the
//   input register; it moves on as soon as the result register frees up, or
//   at once if it makes no record.
// Reset: position, frame state and entry count clear, header_offset = 46,
//   required_version = 1; no clearing pass, the block is ready at once.
// ---------------------------------------------------------------------------
module someip_header_filter_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_record_kind,
   output logic [15:0] rsp_svc_ident,
   output logic [15:0] rsp_second_id,
   output logic [15:0] rsp_third_id,
   output logic [15:0] rsp_sess_ident,
   output logic [31:0] rsp_long_value,
   output logic [31:0] rsp_entries_bytes,
   output logic [7:0]  rsp_discovery_flags,
   output logic [7:0]  rsp_byte_a,
   output logic [7:0]  rsp_byte_b,
   output logic [7:0]  rsp_byte_c,
   output logic        rsp_end_of_packet,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sipf_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       req_take;
   logic       fire;
   logic       out_space;
   result_type result;
   record_type out_rec;

   assign req_take  = req_valid && req_ready;
   assign out_space = !rsp_valid || rsp_ready;
   // a byte that makes no record never waits on the result register
   assign fire      = in_valid_ff && (!result.valid || out_space);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   sipf_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fire         (fire),
      .data_byte    (in_data_ff),
      .last_byte    (in_last_ff),
      .result       (result)
   );

   sipf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && result.valid),
      .push_rec  (result.rec),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_rec   (out_rec)
   );

   assign rsp_record_kind     = out_rec.kind;
   assign rsp_svc_ident       = out_rec.svc_ident;
   assign rsp_second_id       = out_rec.second_id;
   assign rsp_third_id        = out_rec.third_id;
   assign rsp_sess_ident      = out_rec.sess_ident;
   assign rsp_long_value      = out_rec.long_value;
   assign rsp_entries_bytes   = out_rec.entries_bytes;
   assign rsp_discovery_flags = out_rec.discovery_flags;
   assign rsp_byte_a          = out_rec.byte_a;
   assign rsp_byte_b          = out_rec.byte_b;
   assign rsp_byte_c          = out_rec.byte_c;
   assign rsp_end_of_packet   = out_rec.end_of_packet;

   // end and short records only close a frame
   a_end_kinds_flagged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_record_kind == KIND_END) || (rsp_record_kind == KIND_SHORT))
      |-> rsp_end_of_packet)
      else $error("end/short record without end_of_packet");

   // discovery length and flags only on the discovery header record
   a_disc_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind != KIND_DISCOVERY)
      |-> (rsp_entries_bytes == '0) && (rsp_discovery_flags == '0))
      else $error("discovery fields set on a non-discovery record");

   // entries carry no session ID
   a_entry_session: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_record_kind == KIND_SVC_ENTRY) ||
                    (rsp_record_kind == KIND_EG_ENTRY) ||
                    (rsp_record_kind == KIND_OTHER_ENTRY))
      |-> (rsp_sess_ident == '0))
      else $error("entry record with nonzero session ID");

   // a byte held in the input register must leave once the result side is free
   a_input_drains: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid |-> req_ready)
      else $error("input register stuck while result register empty");

endmodule

// ===== hdl/sipf_parse.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sipf_parse
// Frame position tracking, header/entry capture and record decode for the
// byte held in the input register. State advances only when fire is high.
// ---------------------------------------------------------------------------
module sipf_parse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sipf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sipf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 fire,
   input  logic [7:0]                           data_byte,
   input  logic                                 last_byte,
   output sipf_pkg::result_type                 result
);
   import sipf_pkg::*;

   logic [7:0]                   offset_ff, offset_in;
   logic [7:0]                   version_ff, version_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic [ENTRIES_LEFT_BITS-1:0] left_ff, left_in;
   status_type                   status_ff, status_in;
   logic [7:0]                   hdr_ff [PREFIX_END];
   logic [7:0]                   ent_ff [ENTRY_LEN];

   logic [POSITION_BITS-1:0]  rel;
   logic                      parse_en;
   logic                      hdr_wr;
   logic                      ent_wr;
   logic [HDR_IDX_BITS-1:0]   hdr_idx;
   logic [ENTRY_IDX_BITS-1:0] ent_idx;
   logic [7:0]                hv [PREFIX_END];
   logic [7:0]                ev [ENTRY_LEN];
   logic [15:0]               svc;
   logic [31:0]               sd_len;
   record_type                hdr_rec;
   record_type                ent_rec;
   record_type                rec;
   logic                      have;

   // config registers
   always_comb begin
      offset_in  = offset_ff;
      version_in = version_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HEADER_OFFSET:    offset_in  = csr_wdata;
            CSR_REQUIRED_VERSION: version_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign parse_en = (pos_ff != '1) && (pos_ff >= POSITION_BITS'(offset_ff));
   assign rel      = pos_ff - POSITION_BITS'(offset_ff);
   assign hdr_idx  = rel[HDR_IDX_BITS-1:0];
   // entries start at byte 24 of the message, so the slot is offset by 24 mod 16
   assign ent_idx  = rel[ENTRY_IDX_BITS-1:0] + ENTRY_IDX_BITS'(PREFIX_END % ENTRY_LEN);
   assign hdr_wr   = parse_en &&
                     (((status_ff == ST_HEADER) && (rel < POSITION_BITS'(HDR_LEN))) ||
                      ((status_ff == ST_PREFIX) && (rel < POSITION_BITS'(PREFIX_END))));
   assign ent_wr   = parse_en && (status_ff == ST_ENTRIES) &&
                     (rel >= POSITION_BITS'(PREFIX_END));

   // stored bytes with the current byte folded in
   always_comb begin
      for (int i = 0; i < PREFIX_END; i++) begin
         hv[i] = (hdr_wr && (hdr_idx == HDR_IDX_BITS'(i))) ? data_byte : hdr_ff[i];
      end
      for (int i = 0; i < ENTRY_LEN; i++) begin
         ev[i] = (ent_wr && (ent_idx == ENTRY_IDX_BITS'(i))) ? data_byte : ent_ff[i];
      end
   end

   assign svc    = {hv[0], hv[1]};
   assign sd_len = {hv[20], hv[21], hv[22], hv[23]};

   always_comb begin
      hdr_rec            = '0;
      hdr_rec.svc_ident  = svc;
      hdr_rec.second_id  = {hv[2], hv[3]};
      hdr_rec.long_value = {hv[4], hv[5], hv[6], hv[7]};
      hdr_rec.third_id   = {hv[8], hv[9]};
      hdr_rec.sess_ident = {hv[10], hv[11]};
      hdr_rec.byte_a     = hv[13];
      hdr_rec.byte_b     = hv[14];
      hdr_rec.byte_c     = hv[15];
   end

   always_comb begin
      ent_rec            = '0;
      ent_rec.svc_ident  = {ev[4], ev[5]};
      ent_rec.second_id  = {ev[6], ev[7]};
      ent_rec.byte_a     = ev[0];
      ent_rec.byte_b     = ev[8];
      if (ev[0] inside {ET_FIND_SERVICE, ET_OFFER_SERVICE}) begin
         ent_rec.kind       = KIND_SVC_ENTRY;
         ent_rec.long_value = {ev[12], ev[13], ev[14], ev[15]};
      end else if (ev[0] inside {ET_SUBSCRIBE, ET_SUBSCRIBE_ACK}) begin
         ent_rec.kind     = KIND_EG_ENTRY;
         ent_rec.byte_c   = {4'h0, ev[13][3:0]};
         ent_rec.third_id = {ev[14], ev[15]};
      end else begin
         ent_rec.kind = KIND_OTHER_ENTRY;
      end
   end

   always_comb begin
      rec       = '0;
      have      = 1'b0;
      status_in = status_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      if (parse_en) begin
         case (status_ff)
            ST_HEADER: begin
               if (rel == POSITION_BITS'(HDR_LEN - 1)) begin
                  rec       = hdr_rec;
                  have      = 1'b1;
                  status_in = ST_DONE;
                  if (!is_known(svc)) begin
                     rec.kind = KIND_UNKNOWN;
                  end else if (hv[12] != version_ff) begin
                     rec.kind = KIND_BAD_VERSION;
                  end else if (svc == DISCOVERY_ID) begin
                     // discovery header is reported once the prefix is in
                     rec       = '0;
                     have      = 1'b0;
                     status_in = ST_PREFIX;
                  end else begin
                     rec.kind = KIND_HEADER;
                  end
               end
            end
            ST_PREFIX: begin
               if (rel == POSITION_BITS'(PREFIX_END - 1)) begin
                  rec                 = hdr_rec;
                  rec.kind            = KIND_DISCOVERY;
                  rec.entries_bytes   = sd_len;
                  rec.discovery_flags = hv[16];
                  have                = 1'b1;
                  left_in             = sd_len[31:4];
                  status_in           = (sd_len[31:4] != '0) ? ST_ENTRIES : ST_DONE;
               end
            end
            ST_ENTRIES: begin
               if (ent_wr && (ent_idx == '1)) begin
                  rec     = ent_rec;
                  have    = 1'b1;
                  left_in = left_ff - ENTRIES_LEFT_BITS'(1);
                  if (left_in == '0) begin
                     status_in = ST_DONE;
                  end
               end
            end
            default: ;
         endcase
      end
      if (last_byte) begin
         if (!have) begin
            rec      = '0;
            rec.kind = ((status_in == ST_HEADER) || (status_in == ST_PREFIX)) ?
                       KIND_SHORT : KIND_END;
            have     = 1'b1;
         end
         rec.end_of_packet = 1'b1;
         pos_in            = '0;
         left_in           = '0;
         status_in         = ST_HEADER;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
   end

   assign result.valid = have;
   assign result.rec   = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= HEADER_OFFSET_RESET;
         version_ff <= VERSION_RESET;
         pos_ff     <= '0;
         left_ff    <= '0;
         status_ff  <= ST_HEADER;
      end else begin
         offset_ff  <= offset_in;
         version_ff <= version_in;
         if (fire) begin
            pos_ff    <= pos_in;
            left_ff   <= left_in;
            status_ff <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hdr_wr) begin
         hdr_ff[hdr_idx] <= data_byte;
      end
      if (fire && ent_wr) begin
         ent_ff[ent_idx] <= data_byte;
      end
   end

endmodule

// ===== hdl/sipf_out_reg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sipf_out_reg
// Result register: holds one record until the receiver takes it.
// ---------------------------------------------------------------------------
module sipf_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sipf_pkg::record_type push_rec,
   input  logic                 out_ready,
   output logic                 out_valid,
   output sipf_pkg::record_type out_rec
);
   import sipf_pkg::*;

   logic       valid_ff, valid_in;
   record_type rec_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff <= push_rec;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

endmodule
